[sv/llts_pkg.sv]
package llts_pkg;

	localparam int MAX_TASKS  = 3;
	localparam int TIMING_W   = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int TASK_IDX_W = 2;
	localparam int LAXITY_W   = 17;

	localparam logic [TASK_IDX_W-1:0] IDLE_TASK = 2'd3;

	// Timing register sub-field positions.
	localparam int BUDGET_LSB = 32;
	localparam int PERIOD_LSB = 16;
	localparam int OFFSET_LSB = 0;

	typedef struct packed {
		logic                active;
		logic                released;
		logic [LAXITY_W-1:0] laxity;
	} task_status_t;

	typedef struct packed {
		logic [TASK_IDX_W-1:0] task_sel;
		logic [LAXITY_W-1:0]   laxity;
		logic                  missed;
		logic [MAX_TASKS-1:0]  released;
	} pick_result_t;

endpackage

[sv/llts_if.sv]
interface llts_req_if;
	logic valid;
	logic ready;
	logic run_tick;

	modport source (output valid, output run_tick, input ready);
	modport sink (input valid, input run_tick, output ready);
endinterface

interface llts_rsp_if;
	import llts_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [TASK_IDX_W-1:0] selected_task;
	logic [LAXITY_W-1:0]   selected_laxity;
	logic                  deadline_missed;
	logic [MAX_TASKS-1:0]  released_mask;

	modport source (output valid, output selected_task, output selected_laxity,
		output deadline_missed, output released_mask, input ready);
	modport sink (input valid, input selected_task, input selected_laxity,
		input deadline_missed, input released_mask, output ready);
endinterface

[sv/least_laxity_task_selector.sv]
// Least-laxity-first selector for up to three periodic tasks.
// Each task is set up through the write port: cfg_index selects the task's
// timing register and cfg_data carries budget (47:32), period (31:16) and
// release offset (15:0). A period of zero disables the task. Write only
// while no beat is in flight.
//
// Every beat on req is one timer tick. With run_tick high the tick is
// executed: releases are applied, the task with the least laxity loses one
// unit of work, phases advance and deadlines count down. With run_tick low
// the same answer is reported and nothing changes. Each request beat gives
// exactly one rsp beat with the chosen task (3 when idle), its laxity, a
// deadline-miss flag and the mask of tasks released on that tick.
//
// A request beat is registered in the request stage, then evaluated into the
// result register, whose content is offered on rsp. While rsp takes results,
// one beat per cycle is sustained; the state update of a tick lands in the
// same edge that loads its result, so the next tick sees it at once. When rsp
// stalls, the result register and the request stage hold and req.ready drops
// only while both are full. Reset clears timing registers, task state and all
// valid flags.
module least_laxity_task_selector #(
	parameter int TASK_COUNT = 3,
	parameter int TIME_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [llts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [llts_pkg::TIMING_W-1:0]   cfg_data,
	llts_req_if.sink                        req,
	llts_rsp_if.source                      rsp
);
	import llts_pkg::*;

	logic [TIME_BITS-1:0] budget_q [TASK_COUNT];
	logic [TIME_BITS-1:0] period_q [TASK_COUNT];
	logic [TIME_BITS-1:0] offset_q [TASK_COUNT];

	logic valid_s1;
	logic run_tick_s1;
	logic advance;
	logic commit;

	task_status_t status_w [TASK_COUNT];
	pick_result_t result_w;

	logic         out_valid_q;
	pick_result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				budget_q[i] <= '0;
				period_q[i] <= '0;
				offset_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					budget_q[i] <= cfg_data[BUDGET_LSB +: TIME_BITS];
					period_q[i] <= cfg_data[PERIOD_LSB +: TIME_BITS];
					offset_q[i] <= cfg_data[OFFSET_LSB +: TIME_BITS];
				end
			end
		end
	end

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign commit    = advance && run_tick_s1;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			run_tick_s1 <= req.run_tick;
	end

	for (genvar g = 0; g < TASK_COUNT; g++) begin : g_task
		llts_task #(
			.TIME_BITS(TIME_BITS)
		) u_task (
			.clk    (clk),
			.arst_n (arst_n),
			.budget (budget_q[g]),
			.period (period_q[g]),
			.offset (offset_q[g]),
			.commit (commit),
			.take   (result_w.task_sel == TASK_IDX_W'(g)),
			.status (status_w[g])
		);
	end

	llts_pick #(
		.TASK_COUNT(TASK_COUNT)
	) u_pick (
		.status (status_w),
		.result (result_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result_w;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.selected_task   = out_q.task_sel;
	assign rsp.selected_laxity = out_q.laxity;
	assign rsp.deadline_missed = out_q.missed;
	assign rsp.released_mask   = out_q.released;

endmodule

[sv/llts_task.sv]
module llts_task #(
	parameter int TIME_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [TIME_BITS-1:0]       budget,
	input  logic [TIME_BITS-1:0]       period,
	input  logic [TIME_BITS-1:0]       offset,
	input  logic                       commit,
	input  logic                       take,
	output llts_pkg::task_status_t     status
);
	import llts_pkg::*;

	logic [TIME_BITS-1:0] phase_q;
	logic [TIME_BITS-1:0] ttd_q;
	logic [TIME_BITS-1:0] work_q;

	logic                 enabled;
	logic                 release_w;
	logic [TIME_BITS-1:0] work_eff;
	logic [TIME_BITS-1:0] ttd_eff;
	logic signed [TIME_BITS:0] lax_w;
	logic [TIME_BITS:0]   phase_inc;

	assign enabled   = period != '0;
	assign release_w = enabled && (phase_q == offset);
	assign work_eff  = release_w ? budget : work_q;
	assign ttd_eff   = release_w ? period : ttd_q;
	assign lax_w     = $signed({1'b0, ttd_eff}) - $signed({1'b0, work_eff});
	assign phase_inc = {1'b0, phase_q} + {{TIME_BITS{1'b0}}, 1'b1};

	assign status.active   = enabled && (work_eff != '0);
	assign status.released = release_w;
	assign status.laxity   = LAXITY_W'(lax_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			ttd_q   <= '0;
			work_q  <= '0;
		end else if (commit) begin
			// A disabled task never wins, so its work and deadline simply hold.
			work_q <= work_eff - {{(TIME_BITS-1){1'b0}}, take};
			if (enabled && ttd_eff != '0)
				ttd_q <= ttd_eff - {{(TIME_BITS-1){1'b0}}, 1'b1};
			else
				ttd_q <= ttd_eff;
			if (!enabled || phase_inc >= {1'b0, period})
				phase_q <= '0;
			else
				phase_q <= phase_inc[TIME_BITS-1:0];
		end
	end

endmodule

[sv/llts_pick.sv]
module llts_pick #(
	parameter int TASK_COUNT = 3
) (
	input  llts_pkg::task_status_t status [TASK_COUNT],
	output llts_pkg::pick_result_t result
);
	import llts_pkg::*;

	always_comb begin
		logic                found;
		logic [LAXITY_W-1:0] best;
		found           = 1'b0;
		best            = '0;
		result.task_sel = IDLE_TASK;
		result.missed   = 1'b0;
		result.released = '0;
		// Strict less-than keeps the lowest index on a tie.
		for (int i = 0; i < TASK_COUNT; i++) begin
			result.released[i] = status[i].released;
			if (status[i].active) begin
				if ($signed(status[i].laxity) < 0)
					result.missed = 1'b1;
				if (!found || $signed(status[i].laxity) < $signed(best)) begin
					found           = 1'b1;
					best            = status[i].laxity;
					result.task_sel = TASK_IDX_W'(i);
				end
			end
		end
		result.laxity = best;
	end

endmodule

[sv/llts_checker.sv]
module llts_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [llts_pkg::TASK_IDX_W-1:0] rsp_task,
	input logic [llts_pkg::LAXITY_W-1:0]   rsp_laxity,
	input logic                            rsp_missed
);
	import llts_pkg::*;

	// Every request beat has its result showing on rsp once it has passed the request stage and the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("result missing two cycles after a request beat");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_task == IDLE_TASK |-> rsp_laxity == '0 && !rsp_missed)
		else $error("idle result carries laxity or a miss");

	a_neg_missed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_laxity[LAXITY_W-1] |-> rsp_missed)
		else $error("negative laxity chosen without a miss flag");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

endmodule

bind least_laxity_task_selector llts_checker u_llts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_task   (rsp.selected_task),
	.rsp_laxity (rsp.selected_laxity),
	.rsp_missed (rsp.deadline_missed)
);
